// ----- src/fpcm_pkg.sv -----
// Package with payload types, mode codes, the queue depth and the float-to-integer scale constants.
package fpcm_pkg;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        final_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       sample_last_byte;
    logic       stream_end;
  } out_item_t;

  // Converted word waiting for serialisation.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  nbytes_m1;
    logic        fin;
  } job_t;

  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_24 = 2'd1;
  localparam logic [1:0] MODE_32 = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  // Scale constants: 24-bit significands including the hidden bit, and exponents.
  // 32767 = 0x7FFF, 8388607 = 0x7FFFFF exactly; 2147483647 rounds to 2^31.
  localparam logic [23:0] MANT_16 = 24'hFFFE00;
  localparam logic [23:0] MANT_24 = 24'hFFFFFE;
  localparam logic [23:0] MANT_32 = 24'h800000;
  localparam logic [7:0]  EXP_16 = 8'd141;
  localparam logic [7:0]  EXP_24 = 8'd149;
  localparam logic [7:0]  EXP_32 = 8'd158;

endpackage

// ----- src/fpcm_front.sv -----
// Front end: clamps the sample, multiplies by the scale, rounds to single and truncates.
module fpcm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpcm_pkg::in_item_t in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output fpcm_pkg::job_t     job_data
);

  // Stage 1 registers: clamped operand significand and exponent, scale choice.
  logic        s1_valid_r;
  logic        s1_zero_r;
  logic        s1_sign_r;
  logic [23:0] s1_mant_r;
  logic [7:0]  s1_exp_r;
  logic [23:0] s1_smant_r;
  logic [7:0]  s1_sexp_r;
  logic        s1_sat_r;
  logic [1:0]  s1_nb_r;
  logic        s1_fin_r;
  // Stage 2 registers: raw product.
  logic        s2_valid_r;
  logic        s2_zero_r;
  logic        s2_sign_r;
  logic [47:0] s2_prod_r;
  logic [8:0]  s2_exp_r;
  logic        s2_sat_r;
  logic [1:0]  s2_nb_r;
  logic        s2_fin_r;
  // Output register.
  logic           out_valid_r;
  fpcm_pkg::job_t out_r;

  logic adv2, adv1, adv0;
  assign adv2 = !out_valid_r || job_ready;
  assign adv1 = !s2_valid_r || adv2;
  assign adv0 = !s1_valid_r || adv1;
  assign in_ready  = adv0;
  assign job_valid = out_valid_r;
  assign job_data  = out_r;

  // Input classification.
  logic        x_sign;
  logic [7:0]  x_exp;
  logic [22:0] x_frac;
  logic        x_nan, x_big, x_zero;
  logic [23:0] c_mant;
  logic [7:0]  c_exp;
  logic [23:0] sc_mant;
  logic [7:0]  sc_exp;
  logic [1:0]  nb;
  always_comb begin
    x_sign = in_data.sample_bits[31];
    x_exp  = in_data.sample_bits[30:23];
    x_frac = in_data.sample_bits[22:0];
    x_nan  = (x_exp == 8'hFF) && (x_frac != 23'd0);
    x_big  = (x_exp >= 8'd127);
    // Denormals times at most 2^31 stay far below one, so they truncate to zero.
    x_zero = x_nan || (x_exp == 8'd0);
    if (x_big) begin
      c_mant = 24'h800000;
      c_exp  = 8'd127;
    end else begin
      c_mant = {1'b1, x_frac};
      c_exp  = x_exp;
    end
    unique case (mode)
      fpcm_pkg::MODE_16: begin
        sc_mant = fpcm_pkg::MANT_16; sc_exp = fpcm_pkg::EXP_16; nb = 2'd1;
      end
      fpcm_pkg::MODE_24: begin
        sc_mant = fpcm_pkg::MANT_24; sc_exp = fpcm_pkg::EXP_24; nb = 2'd2;
      end
      default: begin
        sc_mant = fpcm_pkg::MANT_32; sc_exp = fpcm_pkg::EXP_32; nb = 2'd3;
      end
    endcase
  end

  // Stage 2 rounding: normalise product to 24 bits with round to nearest even.
  logic        p_top;
  logic [23:0] r_mant;
  logic        r_guard, r_sticky;
  logic [24:0] r_sum;
  logic [23:0] n_mant;
  logic [8:0]  n_exp;
  logic [8:0]  sh;
  logic [55:0] wide;
  logic [31:0] ival;
  logic [31:0] word;
  always_comb begin
    p_top = s2_prod_r[47];
    if (p_top) begin
      r_mant   = s2_prod_r[47:24];
      r_guard  = s2_prod_r[23];
      r_sticky = |s2_prod_r[22:0];
    end else begin
      r_mant   = s2_prod_r[46:23];
      r_guard  = s2_prod_r[22];
      r_sticky = |s2_prod_r[21:0];
    end
    r_sum = {1'b0, r_mant} + {24'd0, r_guard && (r_sticky || r_mant[0])};
    n_exp = s2_exp_r + {8'd0, p_top} + {8'd0, r_sum[24]};
    n_mant = r_sum[24] ? r_sum[24:1] : r_sum[23:0];
    // Value = n_mant * 2^(n_exp - 127 - 23); integer part via shift.
    wide = '0;
    ival = '0;
    if (n_exp >= 9'd127) begin
      sh = n_exp - 9'd127;
      if (sh <= 9'd30) begin
        wide = {32'd0, n_mant} << sh[4:0];
        ival = wide[54:23];
      end
    end else begin
      sh = '0;
    end
    if (s2_zero_r) word = '0;
    else if (s2_sat_r) word = s2_sign_r ? 32'h80000000 : 32'h7FFFFFFF;
    else word = s2_sign_r ? (~ival + 32'd1) : ival;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv0) s1_valid_r <= in_valid && in_ready && (mode != fpcm_pkg::MODE_NONE);
      if (adv1) s2_valid_r <= s1_valid_r;
      if (adv2) out_valid_r <= s2_valid_r;
    end
    if (adv0) begin
      s1_zero_r  <= x_zero;
      s1_sign_r  <= x_sign;
      s1_mant_r  <= c_mant;
      s1_exp_r   <= c_exp;
      s1_smant_r <= sc_mant;
      s1_sexp_r  <= sc_exp;
      // In 32-bit mode only a clamped full-scale input reaches 2^31.
      s1_sat_r   <= (mode == fpcm_pkg::MODE_32) && x_big;
      s1_nb_r    <= nb;
      s1_fin_r   <= in_data.final_sample;
    end
    if (adv1) begin
      s2_zero_r <= s1_zero_r;
      s2_sign_r <= s1_sign_r;
      s2_prod_r <= s1_mant_r * s1_smant_r;
      s2_exp_r  <= {1'b0, s1_exp_r} + {1'b0, s1_sexp_r} - 9'd127;
      s2_sat_r  <= s1_sat_r;
      s2_nb_r   <= s1_nb_r;
      s2_fin_r  <= s1_fin_r;
    end
    if (adv2) begin
      out_r.word      <= word;
      out_r.nbytes_m1 <= s2_nb_r;
      out_r.fin       <= s2_fin_r;
    end
  end

endmodule

// ----- src/fpcm_queue.sv -----
// Small first-in first-out queue between the converter and the byte serialiser.
module fpcm_queue #(
  parameter int DEPTH = fpcm_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  fpcm_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output fpcm_pkg::job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fpcm_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ----- src/fpcm_back.sv -----
// Back end: emits a converted word as little-endian bytes with end markers.
module fpcm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  fpcm_pkg::job_t      job_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fpcm_pkg::out_item_t out_data
);

  logic [1:0] idx_r;
  logic       last;

  assign last      = (idx_r == job_data.nbytes_m1);
  assign out_valid = job_valid;
  assign job_ready = out_ready && last;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_data.out_byte = job_data.word[7:0];
      2'd1:    out_data.out_byte = job_data.word[15:8];
      2'd2:    out_data.out_byte = job_data.word[23:16];
      default: out_data.out_byte = job_data.word[31:24];
    endcase
    out_data.sample_last_byte = last;
    out_data.stream_end       = last && job_data.fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (job_valid && out_ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ----- src/float_to_pcm_byte_serializer_top.sv -----
// Top level of the float-to-PCM byte serialiser.
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one single-precision
// sample bit pattern and a final-sample flag per transfer. The sample is
// clamped to [-1, 1], scaled in single precision for the chosen bit depth and
// truncated toward zero. The output channel (out_valid, out_ready, out_data)
// then carries 2, 3 or 4 bytes, least significant first; the last byte of each
// sample is flagged, and so is the last byte of a final sample.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the bit
// depth: 0 for 16 bit, 1 for 24 bit, 2 for 32 bit. Mode 3 swallows samples.
// The converter is three register stages deep (stage 1, stage 2 and the
// output register), and each converted word then passes through the queue.
// The serialiser, which owns the byte output alone, emits one byte per cycle
// while the queue holds a word and out_ready is high.
// Reset clears the pipeline, the queue and the mode (16 bit).
// When the receiver stalls, the serialiser holds its byte, the queue fills and
// the converter stages back up in turn before in_ready falls.
module float_to_pcm_byte_serializer_top #(
  parameter int QUEUE_DEPTH = fpcm_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpcm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fpcm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  logic [1:0] mode_r;

  // Cfg always accepted; user writes only while the block idles (unchecked).
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fpcm_pkg::MODE_16;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  logic           f_valid, f_ready, q_valid, q_ready;
  fpcm_pkg::job_t f_data, q_data;

  fpcm_front u_front (
    .clk, .rst_n, .mode(mode_r),
    .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
  );

  fpcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  fpcm_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid, .out_ready, .out_data
  );

endmodule
